### design/fwrc_pkg.sv
// fwrc_pkg: shared types and constants for the framed word receiver.
// No dependencies; imported by every other file of the block.
package fwrc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned STAT_W  = 3;

	localparam logic [COUNT_W-1:0] FRAME_LEN = 3'd6;
	localparam logic [COUNT_W-1:0] CRC_SPAN  = 3'd4;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h02;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h03;
	localparam logic [WORD_W-1:0] CRC_INIT   = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY   = 16'hA001;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_LENGTH = 3'd1,
		ST_START  = 3'd2,
		ST_END    = 3'd3,
		ST_CRC    = 3'd4
	} fwrc_status_t;

	// Closing verdict handed from the frame tracker to the result register.
	typedef struct packed {
		logic                close;
		logic [WORD_W-1:0]   value;
		fwrc_status_t        status;
	} fwrc_close_t;

endpackage

### design/fwrc_if.sv
// fwrc_if: valid/ready channel interfaces for received bytes and frame results.
// Depends on fwrc_pkg for field widths.
interface fwrc_byte_if import fwrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              chunk_end;

	modport source (output valid, output rx_byte, output chunk_end, input ready);
	modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface fwrc_result_if import fwrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] frame_value;
	logic [STAT_W-1:0] frame_status;

	modport source (output valid, output frame_value, output frame_status, input ready);
	modport sink   (input valid, input frame_value, input frame_status, output ready);
endinterface

### design/fwrc_crc_byte.sv
// fwrc_crc_byte: one byte step of the reflected CRC-16 (eight bit steps unrolled).
// Depends on fwrc_pkg.
module fwrc_crc_byte import fwrc_pkg::*; (
	input  logic [WORD_W-1:0] crc_in,
	input  logic [BYTE_W-1:0] data,
	output logic [WORD_W-1:0] crc_out
);

	always_comb begin
		logic [WORD_W-1:0] c;
		c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

### design/fwrc_frame_track.sv
// fwrc_frame_track: per-chunk state (count, CRC, fields) and closing verdict.
// Depends on fwrc_pkg and fwrc_crc_byte.
module fwrc_frame_track import fwrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              chunk_end,
	output fwrc_close_t       verdict
);

	localparam logic [COUNT_W-1:0] POS_START = 3'd0;
	localparam logic [COUNT_W-1:0] POS_HIGH  = 3'd1;
	localparam logic [COUNT_W-1:0] POS_LOW   = 3'd2;
	localparam logic [COUNT_W-1:0] POS_END   = 3'd3;
	localparam logic [COUNT_W-1:0] POS_CRC_L = 3'd4;
	localparam logic [COUNT_W-1:0] POS_CRC_H = 3'd5;

	logic [WORD_W-1:0]  crc_q, crc_fed, crc_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [WORD_W-1:0]  word_q, word_d;
	logic [BYTE_W-1:0]  crc_lo_q, crc_lo_d;
	logic               start_ok_q, start_ok_d;
	logic               end_ok_q, end_ok_d;
	logic [WORD_W-1:0]  rx_crc_q, rx_crc_d;
	fwrc_status_t       status;

	fwrc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_fed)
	);

	always_comb begin
		crc_d      = (count_q < CRC_SPAN) ? crc_fed : crc_q;
		word_d     = word_q;
		crc_lo_d   = crc_lo_q;
		start_ok_d = start_ok_q;
		end_ok_d   = end_ok_q;
		rx_crc_d   = rx_crc_q;
		unique case (count_q)
			POS_START: start_ok_d = (rx_byte == START_BYTE);
			POS_HIGH:  word_d     = {rx_byte, word_q[BYTE_W-1:0]};
			POS_LOW:   word_d     = {word_q[WORD_W-1:BYTE_W], rx_byte};
			POS_END:   end_ok_d   = (rx_byte == END_BYTE);
			POS_CRC_L: crc_lo_d   = rx_byte;
			POS_CRC_H: rx_crc_d   = {rx_byte, crc_lo_q};
			default:   ;
		endcase
		count_d = (count_q < COUNT_MAX) ? count_q + 3'd1 : count_q;
	end

	// First failing check wins.
	always_comb begin
		priority if (count_d != FRAME_LEN) begin
			status = ST_LENGTH;
		end else if (!start_ok_d) begin
			status = ST_START;
		end else if (!end_ok_d) begin
			status = ST_END;
		end else if (rx_crc_d != crc_d) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end
	end

	assign verdict.close  = take && chunk_end;
	assign verdict.status = status;
	assign verdict.value  = (status == ST_OK) ? word_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			count_q    <= '0;
			word_q     <= '0;
			crc_lo_q   <= '0;
			start_ok_q <= 1'b0;
			end_ok_q   <= 1'b0;
			rx_crc_q   <= '0;
		end else if (take) begin
			if (chunk_end) begin
				crc_q      <= CRC_INIT;
				count_q    <= '0;
				word_q     <= '0;
				crc_lo_q   <= '0;
				start_ok_q <= 1'b0;
				end_ok_q   <= 1'b0;
				rx_crc_q   <= '0;
			end else begin
				crc_q      <= crc_d;
				count_q    <= count_d;
				word_q     <= word_d;
				crc_lo_q   <= crc_lo_d;
				start_ok_q <= start_ok_d;
				end_ok_q   <= end_ok_d;
				rx_crc_q   <= rx_crc_d;
			end
		end
	end

endmodule

### design/fwrc_result_reg.sv
// fwrc_result_reg: output register holding one frame result until taken.
// Depends on fwrc_pkg and fwrc_if.
module fwrc_result_reg import fwrc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fwrc_close_t          verdict,
	output logic                 space,
	fwrc_result_if.source        result
);

	logic              valid_q;
	logic [WORD_W-1:0] value_q;
	logic [STAT_W-1:0] status_q;

	// Room when empty or when the held request leaves this cycle.
	assign space = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= verdict.close;
		end
	end

	always_ff @(posedge clk) begin
		if (space && verdict.close) begin
			value_q  <= verdict.value;
			status_q <= verdict.status;
		end
	end

	assign result.valid        = valid_q;
	assign result.frame_value  = value_q;
	assign result.frame_status = status_q;

endmodule

### design/framed_word_receiver_crc16_unit.sv
// framed_word_receiver_crc16_unit: top level of the framed word receiver.
// Depends on fwrc_pkg, fwrc_if, fwrc_frame_track, fwrc_result_reg.
//
//  channel  dir  request carries            width
//  -------  ---  -------------------------  -----
//  rx       in   rx_byte, chunk_end         8 + 1
//  result   out  frame_value, frame_status  16 + 3
//
// One byte request is taken every cycle while the output register has room.
// The byte goes straight into the chunk state (count, CRC, fields); on a
// closing byte the verdict is written to the output register at the same edge,
// so a result appears in the cycle after its closing byte is taken.
// arst_n clears the chunk state (CRC to 0xFFFF) and empties the output register.
// A stalled result holds rx.ready low only while result.ready is low.
module framed_word_receiver_crc16_unit import fwrc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fwrc_byte_if.sink     rx,
	fwrc_result_if.source result
);

	logic        space;
	logic        take;
	fwrc_close_t verdict;

	// Every byte may close a chunk, so a byte waits for output room.
	assign rx.ready = space;
	assign take     = rx.valid && space;

	// Chunk state: position, running CRC over bytes 0..3, captured fields.
	fwrc_frame_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.chunk_end (rx.chunk_end),
		.verdict   (verdict)
	);

	// Output register: parts the byte side from the result side.
	fwrc_result_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.verdict (verdict),
		.space   (space),
		.result  (result)
	);

endmodule

### tb/fwrc_frame_checker.sv
// fwrc_frame_checker: watches the byte and result channels of the framed word receiver,
// predicts each frame verdict and compares it with what the block hands out.
// Depends on fwrc_pkg for widths, framing constants and the status codes.
`timescale 1ns / 100ps

module fwrc_frame_checker import fwrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	input  logic              rx_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              chunk_end,
	input  logic              res_valid,
	input  logic              res_ready,
	input  logic [WORD_W-1:0] frame_value,
	input  logic [STAT_W-1:0] frame_status,
	output int unsigned       fail_count,
	output int unsigned       frames_owed
);

	typedef struct packed {
		logic [WORD_W-1:0] value;
		fwrc_status_t      status;
	} frame_verdict_t;

	// chunk state as the block should hold it
	logic [WORD_W-1:0]  crc_run;
	logic [COUNT_W-1:0] seen_count;
	logic [WORD_W-1:0]  data_word;
	logic [BYTE_W-1:0]  crc_lo_byte;
	logic               start_ok;
	logic               end_ok;
	logic [WORD_W-1:0]  crc_rx;

	frame_verdict_t verdicts_due[$];
	int unsigned    mismatches;

	function automatic logic [WORD_W-1:0] crc16_step(input logic [WORD_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic restart_chunk();
		crc_run     = CRC_INIT;
		seen_count  = '0;
		data_word   = '0;
		crc_lo_byte = '0;
		start_ok    = 1'b0;
		end_ok      = 1'b0;
		crc_rx      = '0;
	endtask

	task automatic flag_mismatch(input string what);
		$display("%0t fwrc mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Folds one accepted byte into the chunk state; a closing byte queues a verdict.
	task automatic take_rx_byte(input logic [BYTE_W-1:0] b, input logic last);
		frame_verdict_t v;
		if (seen_count < CRC_SPAN)
			crc_run = crc16_step(crc_run, b);
		case (seen_count)
			3'd0: start_ok = (b == START_BYTE);
			3'd1: data_word[15:8] = b;
			3'd2: data_word[7:0] = b;
			3'd3: end_ok = (b == END_BYTE);
			3'd4: crc_lo_byte = b;
			3'd5: crc_rx = {b, crc_lo_byte};
			default: ;
		endcase
		if (seen_count != COUNT_MAX)
			seen_count = seen_count + 1'b1;
		if (last) begin
			if (seen_count != FRAME_LEN)
				v.status = ST_LENGTH;
			else if (!start_ok)
				v.status = ST_START;
			else if (!end_ok)
				v.status = ST_END;
			else if (crc_rx != crc_run)
				v.status = ST_CRC;
			else
				v.status = ST_OK;
			v.value = (v.status == ST_OK) ? data_word : '0;
			verdicts_due.push_back(v);
			restart_chunk();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t want;
		if (!arst_n) begin
			restart_chunk();
			verdicts_due.delete();
			mismatches = 0;
			fail_count  <= 0;
			frames_owed <= 0;
		end else begin
			// results first, so a result can never match a verdict queued at the same edge
			if (res_valid && res_ready) begin
				if (verdicts_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result value %h status %0d",
						frame_value, frame_status));
				end else begin
					want = verdicts_due.pop_front();
					if (frame_status !== want.status)
						flag_mismatch($sformatf("status %0d, expected %0d",
							frame_status, want.status));
					if (frame_value !== want.value)
						flag_mismatch($sformatf("value %h, expected %h",
							frame_value, want.value));
				end
			end
			if (rx_valid && rx_ready)
				take_rx_byte(rx_byte, chunk_end);
			fail_count  <= mismatches;
			frames_owed <= verdicts_due.size();
		end
	end

endmodule

### tb/framed_word_receiver_crc16_unit_tb.sv
// framed_word_receiver_crc16_unit_tb: drives byte requests into the framed word receiver,
// throttles its result channel and gives the verdict. Checking lives in fwrc_frame_checker.
// Depends on fwrc_pkg, fwrc_if, the block and fwrc_frame_checker.
`timescale 1ns / 100ps

module framed_word_receiver_crc16_unit_tb;
	import fwrc_pkg::*;

	localparam int unsigned DIRECTED_BYTES = 25;
	localparam int unsigned RANDOM_BYTES   = 525;
	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int unsigned LONG_HOLD      = 90;

	logic clk = 1'b0;
	logic arst_n;

	fwrc_byte_if   rx_if ();
	fwrc_result_if res_if ();

	int unsigned fail_count;
	int unsigned frames_owed;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;      // no idling on either side while set
	bit          held_long = 1'b0;

	logic [BYTE_W-1:0] chunk_buf [0:15];

	always #6 clk = ~clk;

	framed_word_receiver_crc16_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if)
	);

	fwrc_frame_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_if.valid),
		.rx_ready     (rx_if.ready),
		.rx_byte      (rx_if.rx_byte),
		.chunk_end    (rx_if.chunk_end),
		.res_valid    (res_if.valid),
		.res_ready    (res_if.ready),
		.frame_value  (res_if.frame_value),
		.frame_status (res_if.frame_status),
		.fail_count   (fail_count),
		.frames_owed  (frames_owed)
	);

	// Idle length: mostly none or short, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// CRC of the four framed bytes, as a sender would append it
	function automatic logic [WORD_W-1:0] frame_crc(input logic [31:0] head);
		logic [WORD_W-1:0] c;
		c = CRC_INIT;
		for (int i = 3; i >= 0; i--) begin
			c ^= {8'h00, head[i*8 +: 8]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Fills chunk_buf[0..5] with a frame; crc_flip spoils the trailing CRC.
	task automatic build_frame(input logic [WORD_W-1:0] data, input logic [BYTE_W-1:0] first,
			input logic [BYTE_W-1:0] closing, input logic [WORD_W-1:0] crc_flip);
		logic [WORD_W-1:0] crc;
		crc = frame_crc({first, data, closing}) ^ crc_flip;
		chunk_buf[0] = first;
		chunk_buf[1] = data[15:8];
		chunk_buf[2] = data[7:0];
		chunk_buf[3] = closing;
		chunk_buf[4] = crc[7:0];
		chunk_buf[5] = crc[15:8];
	endtask

	// One byte request; called at a rising edge and returns at the edge it was taken
	// (or after the idle gap that follows it).
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int unsigned gap;
		rx_if.valid     <= 1'b1;
		rx_if.rx_byte   <= b;
		rx_if.chunk_end <= last;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		bytes_sent++;
		gap = gap_len();
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_chunk(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_byte(chunk_buf[i], i == n - 1);
	endtask

	// One random chunk: half well-formed frames, the rest damaged or plain noise.
	task automatic send_random_chunk();
		int unsigned       kind, n;
		logic [BYTE_W-1:0] b;
		logic [WORD_W-1:0] flip;
		kind = $urandom_range(0, 99);
		build_frame(WORD_W'($urandom_range(0, 65535)), START_BYTE, END_BYTE, '0);
		if (kind < 50) begin
			send_chunk(6);
		end else if (kind < 60) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (b == START_BYTE)
				b ^= 8'h01;
			build_frame(WORD_W'($urandom_range(0, 65535)), b, END_BYTE, '0);
			send_chunk(6);
		end else if (kind < 70) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (b == END_BYTE)
				b ^= 8'h80;
			// start byte sometimes wrong too: start outranks end
			build_frame(WORD_W'($urandom_range(0, 65535)),
				($urandom_range(0, 3) == 0) ? 8'h00 : START_BYTE, b, '0);
			send_chunk(6);
		end else if (kind < 80) begin
			flip = WORD_W'($urandom_range(1, 65535));
			build_frame(WORD_W'($urandom_range(0, 65535)), START_BYTE, END_BYTE, flip);
			send_chunk(6);
		end else if (kind < 88) begin
			// long chunk: count runs past six and saturates
			n = $urandom_range(7, 11);
			for (int unsigned i = 6; i < n; i++)
				chunk_buf[i] = BYTE_W'($urandom_range(0, 255));
			send_chunk(n);
		end else if (kind < 94) begin
			send_chunk($urandom_range(1, 5));
		end else begin
			// noise with stray chunk marks; always closes so framing realigns
			n = $urandom_range(1, 10);
			for (int unsigned i = 0; i < n; i++)
				send_byte(BYTE_W'($urandom_range(0, 255)),
					(i == n - 1) || ($urandom_range(0, 4) == 0));
		end
	endtask

	// Result side: runs of readiness broken by stalls; one long hold-off fills the block.
	initial begin
		int unsigned run_len, gap;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_if.ready <= 1'b1;
			run_len = $urandom_range(1, 8);
			repeat (run_len) @(posedge clk);
			if (!held_long && bytes_sent >= 150) begin
				held_long = 1'b1;
				gap = LONG_HOLD;
			end else begin
				gap = gap_len();
			end
			if (gap != 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[framed_word_receiver_crc16_unit] ERROR");
			$finish;
		end
	end

	initial begin
		bit drained;
		drained = 1'b0;
		rx_if.valid     <= 1'b0;
		rx_if.rx_byte   <= '0;
		rx_if.chunk_end <= 1'b0;
		arst_n          <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: good frame at the top data value, then each failure in turn
		// (bad start, bad end, bad CRC) and a lone closing byte.
		build_frame(16'hFFFF, START_BYTE, END_BYTE, '0);
		send_chunk(6);
		build_frame(16'h0000, 8'h00, END_BYTE, '0);
		send_chunk(6);
		build_frame(16'h8001, START_BYTE, 8'hFF, '0);
		send_chunk(6);
		build_frame(16'h1234, START_BYTE, END_BYTE, 16'h0001);
		send_chunk(6);
		send_byte(START_BYTE, 1'b1);

		// Random frames, with a stretch of back-to-back traffic and one full drain.
		while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
			calm = (bytes_sent >= 300 && bytes_sent < 380);
			if (!drained && bytes_sent >= 420) begin
				drained = 1'b1;
				rx_if.valid <= 1'b0;
				@(posedge clk);
				wait (frames_owed == 0);
				@(posedge clk);
			end
			send_random_chunk();
		end
		calm = 1'b0;

		rx_if.valid <= 1'b0;
		@(posedge clk);
		wait (frames_owed == 0);
		repeat (12) @(posedge clk);
		if (fail_count == 0 && frames_owed == 0)
			$display("[framed_word_receiver_crc16_unit] OK");
		else
			$display("[framed_word_receiver_crc16_unit] ERROR");
		$finish;
	end

endmodule

### framed_word_receiver_crc16_unit.f
design/fwrc_pkg.sv
design/fwrc_if.sv
design/fwrc_crc_byte.sv
design/fwrc_frame_track.sv
design/fwrc_result_reg.sv
design/framed_word_receiver_crc16_unit.sv
tb/fwrc_frame_checker.sv
tb/framed_word_receiver_crc16_unit_tb.sv
